// ----- design/ift_pkg.sv -----
`timescale 1ns / 1ps
// ift_pkg: shared types and constants for the image frame transform block.
// Used by ift_ctrl, ift_datapath and image_frame_transform; no dependencies.
package ift_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACCESS,
		ST_MULT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic access;
		logic mult;
		logic finish;
	} dp_cmd_t;

	localparam logic [2:0] MODE_MIRROR_H    = 3'd0;
	localparam logic [2:0] MODE_MIRROR_V    = 3'd1;
	localparam logic [2:0] MODE_MIRROR_BOTH = 3'd2;
	localparam logic [2:0] MODE_ADJUST      = 3'd3;
	localparam logic [2:0] MODE_GREY        = 3'd4;

	localparam logic [2:0] REG_MODE      = 3'd0;
	localparam logic [2:0] REG_COLS      = 3'd1;
	localparam logic [2:0] REG_ROWS      = 3'd2;
	localparam logic [2:0] REG_MAX_VALUE = 3'd3;
	localparam logic [2:0] REG_RED_OFS   = 3'd4;
	localparam logic [2:0] REG_GREEN_OFS = 3'd5;
	localparam logic [2:0] REG_BLUE_OFS  = 3'd6;
	localparam logic [2:0] REG_GREY_THR  = 3'd7;

	localparam logic       ACT_STORE = 1'b0;

	localparam logic [15:0] Q16_RED   = 16'd13933;
	localparam logic [15:0] Q16_GREEN = 16'd46871;
	localparam logic [15:0] Q16_BLUE  = 16'd4732;

endpackage

// ----- design/ift_ctrl.sv -----
`timescale 1ns / 1ps
// ift_ctrl: request sequencer for the image frame transform.
// Depends on ift_pkg (state_t, dp_cmd_t).
module ift_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output ift_pkg::dp_cmd_t cmd
);
	import ift_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_ACCESS;
				end
			end
			ST_ACCESS: begin
				cmd.access = 1'b1;
				state_d    = ST_MULT;
			end
			ST_MULT: begin
				cmd.mult = 1'b1;
				state_d  = ST_FINISH;
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ----- design/ift_datapath.sv -----
`timescale 1ns / 1ps
// ift_datapath: config registers, frame memory and transform arithmetic.
// Depends on ift_pkg; driven by ift_ctrl through dp_cmd_t.
module ift_datapath #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ift_pkg::dp_cmd_t cmd,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [8:0]       cfg_data,
	input  logic             action,
	input  logic [5:0]       row,
	input  logic [5:0]       col,
	input  logic [7:0]       red,
	input  logic [7:0]       green,
	input  logic [7:0]       blue,
	output logic [7:0]       out_red,
	output logic [7:0]       out_green,
	output logic [7:0]       out_blue,
	output logic             coord_error,
	output logic             done
);
	import ift_pkg::*;

	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SZC    = $clog2(MAX_COLS + 1);
	localparam int SZR    = $clog2(MAX_ROWS + 1);
	localparam int SZM    = (SZC > SZR) ? SZC : SZR;
	localparam int SZW    = (SZM > 7) ? SZM : 7;

	function automatic logic [7:0] adjust(input logic [7:0] s, input logic [8:0] ofs,
		input logic [7:0] lim);
		logic signed [9:0] v;
		logic [7:0]        res;
		v = $signed({2'b00, s}) + $signed({ofs[8], ofs});
		if (v < 0) begin
			res = 8'd0;
		end else if (v[8:0] > {1'b0, lim}) begin
			res = lim;
		end else begin
			res = v[7:0];
		end
		return res;
	endfunction

	// config
	logic [2:0] mode_q;
	logic [6:0] cols_q;
	logic [6:0] rows_q;
	logic [7:0] max_q;
	logic [8:0] red_ofs_q;
	logic [8:0] green_ofs_q;
	logic [8:0] blue_ofs_q;
	logic [8:0] thr_q;

	// request
	logic        action_q;
	logic [5:0]  row_q;
	logic [5:0]  col_q;
	logic [23:0] pix_q;

	// memory
	logic [23:0] mem [DEPTH];
	logic [23:0] rd_s1;
	logic        err_s1;
	logic        act_s1;

	logic [7:0] grey_r_s2;
	logic [7:0] grey_g_s2;
	logic [7:0] grey_b_s2;
	logic [7:0] adj_r_s2;
	logic [7:0] adj_g_s2;
	logic [7:0] adj_b_s2;
	logic [23:0] raw_s2;
	logic        err_s2;
	logic        act_s2;

	logic [7:0] out_r_q;
	logic [7:0] out_g_q;
	logic [7:0] out_b_q;
	logic       err_q;
	logic       done_q;

	logic [SZW-1:0] cols_ext;
	logic [SZW-1:0] rows_ext;
	logic [SZW-1:0] ncols;
	logic [SZW-1:0] nrows;
	logic [SZW-1:0] row_ext;
	logic [SZW-1:0] col_ext;
	logic [SZW-1:0] sel_r;
	logic [SZW-1:0] sel_c;
	logic           err;
	logic [AW-1:0]  addr;

	logic [23:0] prod_r;
	logic [23:0] prod_g;
	logic [23:0] prod_b;
	logic [9:0]  grey_sum;
	logic [7:0]  grey_val;
	logic [7:0]  fin_r;
	logic [7:0]  fin_g;
	logic [7:0]  fin_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_MIRROR_H;
			cols_q      <= 7'd64;
			rows_q      <= 7'd64;
			max_q       <= 8'd255;
			red_ofs_q   <= 9'd0;
			green_ofs_q <= 9'd0;
			blue_ofs_q  <= 9'd0;
			thr_q       <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:      mode_q      <= cfg_data[2:0];
				REG_COLS:      cols_q      <= cfg_data[6:0];
				REG_ROWS:      rows_q      <= cfg_data[6:0];
				REG_MAX_VALUE: max_q       <= cfg_data[7:0];
				REG_RED_OFS:   red_ofs_q   <= cfg_data;
				REG_GREEN_OFS: green_ofs_q <= cfg_data;
				REG_BLUE_OFS:  blue_ofs_q  <= cfg_data;
				REG_GREY_THR:  thr_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			row_q    <= row;
			col_q    <= col;
			pix_q    <= {red, green, blue};
		end
	end

	// effective size, bounds check and address; stores are never mirrored
	always_comb begin
		cols_ext = SZW'(cols_q);
		rows_ext = SZW'(rows_q);
		ncols    = (cols_ext > SZW'(MAX_COLS)) ? SZW'(MAX_COLS) : cols_ext;
		nrows    = (rows_ext > SZW'(MAX_ROWS)) ? SZW'(MAX_ROWS) : rows_ext;
		row_ext  = SZW'(row_q);
		col_ext  = SZW'(col_q);
		err      = (row_ext >= nrows) || (col_ext >= ncols);
		sel_r    = row_ext;
		sel_c    = col_ext;
		if (action_q != ACT_STORE) begin
			unique case (mode_q)
				MODE_MIRROR_H: sel_c = ncols - SZW'(1) - col_ext;
				MODE_MIRROR_V: sel_r = nrows - SZW'(1) - row_ext;
				MODE_MIRROR_BOTH: begin
					sel_c = ncols - SZW'(1) - col_ext;
					sel_r = nrows - SZW'(1) - row_ext;
				end
				default: ;
			endcase
		end
		addr = AW'(AW'(sel_r) * AW'(MAX_COLS) + AW'(sel_c));
	end

	always_ff @(posedge clk) begin
		if (cmd.access && (action_q == ACT_STORE) && !err) begin
			mem[addr] <= pix_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.access) begin
			rd_s1 <= mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.access) begin
			err_s1 <= err;
			act_s1 <= action_q;
		end
	end

	assign prod_r = 24'(rd_s1[23:16]) * 24'(Q16_RED);
	assign prod_g = 24'(rd_s1[15:8]) * 24'(Q16_GREEN);
	assign prod_b = 24'(rd_s1[7:0]) * 24'(Q16_BLUE);

	always_ff @(posedge clk) begin
		if (cmd.mult) begin
			grey_r_s2 <= prod_r[23:16];
			grey_g_s2 <= prod_g[23:16];
			grey_b_s2 <= prod_b[23:16];
			adj_r_s2  <= adjust(rd_s1[23:16], red_ofs_q, max_q);
			adj_g_s2  <= adjust(rd_s1[15:8], green_ofs_q, max_q);
			adj_b_s2  <= adjust(rd_s1[7:0], blue_ofs_q, max_q);
			raw_s2    <= rd_s1;
			err_s2    <= err_s1;
			act_s2    <= act_s1;
		end
	end

	always_comb begin
		grey_sum = 10'(grey_r_s2) + 10'(grey_g_s2) + 10'(grey_b_s2);
		grey_val = (grey_sum > 10'(thr_q)) ? 8'd255 : grey_sum[7:0];
		fin_r    = raw_s2[23:16];
		fin_g    = raw_s2[15:8];
		fin_b    = raw_s2[7:0];
		if (err_s2 || (act_s2 == ACT_STORE)) begin
			fin_r = 8'd0;
			fin_g = 8'd0;
			fin_b = 8'd0;
		end else if (mode_q == MODE_ADJUST) begin
			fin_r = adj_r_s2;
			fin_g = adj_g_s2;
			fin_b = adj_b_s2;
		end else if (mode_q == MODE_GREY) begin
			fin_r = grey_val;
			fin_g = grey_val;
			fin_b = grey_val;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_r_q <= fin_r;
			out_g_q <= fin_g;
			out_b_q <= fin_b;
			err_q   <= err_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	assign out_red     = out_r_q;
	assign out_green   = out_g_q;
	assign out_blue    = out_b_q;
	assign coord_error = err_q;
	assign done        = done_q;

endmodule

// ----- design/image_frame_transform.sv -----
`timescale 1ns / 1ps
// image_frame_transform: top level, RGB frame store with mirror/adjust/grey read path.
// Depends on ift_pkg, ift_ctrl and ift_datapath.
//
//   channel   handshake          payload
//   request   start, busy        action, row, col, red, green, blue
//   result    done (1 cycle)     out_red, out_green, out_blue, coord_error
//   config    cfg_we             cfg_index, cfg_data
//
// A request is taken when start is high and busy is low. The sequencer walks
// access, multiply and finish steps, and done is registered from the finish
// step; a new request may be taken in the cycle in which done is high, as busy
// is low again by then. Reset clears the sequencer and the config registers;
// frame memory is not cleared. The receiver cannot stall, so results are never
// held.
module image_frame_transform #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [8:0] cfg_data,
	input  logic       action,
	input  logic [5:0] row,
	input  logic [5:0] col,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic [7:0] out_red,
	output logic [7:0] out_green,
	output logic [7:0] out_blue,
	output logic       coord_error,
	output logic       done
);
	import ift_pkg::*;

	dp_cmd_t cmd;

	ift_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	ift_datapath #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.action      (action),
		.row         (row),
		.col         (col),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.coord_error (coord_error),
		.done        (done)
	);

endmodule

// ----- sim/image_frame_transform_tb.sv -----
`timescale 1ns / 1ps
// image_frame_transform_tb: randomized request/result check of the frame store
// and its mirror, adjust and greyscale read paths. Depends on ift_pkg and image_frame_transform.
module image_frame_transform_tb;
	import ift_pkg::*;

	localparam int  MAX_DIM        = 64;
	localparam int  RANDOM_ITEMS   = 1500;
	localparam int  SETTLE_CYCLES  = 8;
	localparam int  WATCHDOG_LIMIT = 2000;
	localparam bit  ACT_READ       = 1'b1;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       err;
	} pixel_result_t;

	// shadow frame, register copy and pending result queue
	class frame_shadow;
		pixel_result_t pending[$];
		bit [23:0]     pixels[MAX_DIM * MAX_DIM];
		bit            written[MAX_DIM * MAX_DIM];
		int            stored_cells[$];
		bit [2:0]      mode;
		bit [6:0]      cols_reg;
		bit [6:0]      rows_reg;
		bit [7:0]      max_value;
		bit [8:0]      red_ofs;
		bit [8:0]      green_ofs;
		bit [8:0]      blue_ofs;
		bit [8:0]      grey_thr;
		int            errors;

		function new();
			mode      = MODE_MIRROR_H;
			cols_reg  = 7'd64;
			rows_reg  = 7'd64;
			max_value = 8'd255;
			red_ofs   = '0;
			green_ofs = '0;
			blue_ofs  = '0;
			grey_thr  = 9'd256;
			errors    = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [8:0] data);
			case (idx)
				REG_MODE:      mode      = data[2:0];
				REG_COLS:      cols_reg  = data[6:0];
				REG_ROWS:      rows_reg  = data[6:0];
				REG_MAX_VALUE: max_value = data[7:0];
				REG_RED_OFS:   red_ofs   = data;
				REG_GREEN_OFS: green_ofs = data;
				REG_BLUE_OFS:  blue_ofs  = data;
				REG_GREY_THR:  grey_thr  = data;
				default: ;
			endcase
		endfunction

		function int ncols();
			return (cols_reg > MAX_DIM) ? MAX_DIM : int'(cols_reg);
		endfunction

		function int nrows();
			return (rows_reg > MAX_DIM) ? MAX_DIM : int'(rows_reg);
		endfunction

		function bit outside(int r, int c);
			return (r >= nrows()) || (c >= ncols());
		endfunction

		// mirror mapping is its own inverse
		function int source_index(int r, int c);
			int sr;
			int sc;
			sr = r;
			sc = c;
			if (mode == MODE_MIRROR_H || mode == MODE_MIRROR_BOTH)
				sc = ncols() - 1 - c;
			if (mode == MODE_MIRROR_V || mode == MODE_MIRROR_BOTH)
				sr = nrows() - 1 - r;
			return sr * MAX_DIM + sc;
		endfunction

		function bit read_allowed(int r, int c);
			return outside(r, c) || written[source_index(r, c)];
		endfunction

		function bit [7:0] adjust(bit [7:0] s, bit [8:0] ofs);
			int v;
			v = int'(s) + int'($signed(ofs));
			if (v < 0)
				return 8'd0;
			if (v > int'(max_value))
				return max_value;
			return v[7:0];
		endfunction

		function void note_request(bit act, bit [5:0] r, bit [5:0] c,
				bit [7:0] rd, bit [7:0] gr, bit [7:0] bl);
			pixel_result_t res;
			bit [23:0]     px;
			int            idx;
			int            grey;
			res     = '0;
			res.err = outside(r, c);
			idx     = int'(r) * MAX_DIM + int'(c);
			if (act == ACT_STORE) begin
				if (!res.err) begin
					pixels[idx] = {rd, gr, bl};
					if (!written[idx])
						stored_cells.push_back(idx);
					written[idx] = 1'b1;
				end
			end else if (!res.err) begin
				px        = pixels[source_index(r, c)];
				res.red   = px[23:16];
				res.green = px[15:8];
				res.blue  = px[7:0];
				case (mode)
					MODE_ADJUST: begin
						res.red   = adjust(px[23:16], red_ofs);
						res.green = adjust(px[15:8], green_ofs);
						res.blue  = adjust(px[7:0], blue_ofs);
					end
					MODE_GREY: begin
						grey = ((int'(px[23:16]) * int'(Q16_RED)) >> 16)
							+ ((int'(px[15:8]) * int'(Q16_GREEN)) >> 16)
							+ ((int'(px[7:0]) * int'(Q16_BLUE)) >> 16);
						if (grey > int'(grey_thr))
							grey = 255;
						res.red   = grey[7:0];
						res.green = grey[7:0];
						res.blue  = grey[7:0];
					end
					default: ;
				endcase
			end
			pending.push_back(res);
		endfunction

		function void compare(string field, int want, int got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_pixel(pixel_result_t got);
			pixel_result_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual r=%0d g=%0d b=%0d err=%0d",
					$time, got.red, got.green, got.blue, got.err);
				errors++;
				return;
			end
			want = pending.pop_front();
			compare("out_red", want.red, got.red);
			compare("out_green", want.green, got.green);
			compare("out_blue", want.blue, got.blue);
			compare("coord_error", want.err, got.err);
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic       cfg_we;
	logic [2:0] cfg_index;
	logic [8:0] cfg_data;
	logic       action;
	logic [5:0] row;
	logic [5:0] col;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic       coord_error;
	logic       done;

	frame_shadow sb;
	int          stall_cycles;
	int          random_sent;

	image_frame_transform dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.action      (action),
		.row         (row),
		.col         (col),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.coord_error (coord_error),
		.done        (done)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_pixel({out_red, out_green, out_blue, coord_error});
	end

	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) begin
			stall_cycles = 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired", $time);
			$display("*** FAILED ***");
			$finish;
		end else begin
			stall_cycles++;
		end
	end

	function automatic bit [5:0] pick_coord(int lim);
		if (lim > 0 && $urandom_range(0, 9) < 8)
			return 6'($urandom_range(0, lim - 1));
		return 6'($urandom_range(0, 63));
	endfunction

	function automatic bit [7:0] pick_sample();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0)
			return 8'd0;
		if (k == 1)
			return 8'd255;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic int gap_len(bit quiet);
		int k;
		if (quiet)
			return 0;
		k = $urandom_range(0, 99);
		if (k < 50)
			return 0;
		if (k < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// called at a falling edge, returns at the falling edge after the accept
	task automatic send_request(bit act, bit [5:0] r, bit [5:0] c,
			bit [7:0] rd, bit [7:0] gr, bit [7:0] bl);
		action = act;
		row    = r;
		col    = c;
		red    = rd;
		green  = gr;
		blue   = bl;
		start  = 1'b1;
		do @(posedge clk); while (busy);
		sb.note_request(act, r, c, rd, gr, bl);
		@(negedge clk);
	endtask

	task automatic pause(int n);
		start  = 1'b0;
		action = 1'($urandom_range(0, 1));
		row    = 6'($urandom_range(0, 63));
		col    = 6'($urandom_range(0, 63));
		red    = 8'($urandom_range(0, 255));
		green  = 8'($urandom_range(0, 255));
		blue   = 8'($urandom_range(0, 255));
		repeat (n) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [8:0] data);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		sb.set_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic configure(bit [2:0] m, bit [6:0] nc, bit [6:0] nr, bit [7:0] maxv,
			bit [8:0] ro, bit [8:0] go, bit [8:0] bo, bit [8:0] thr);
		start = 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		write_reg(REG_MODE, 9'(m));
		write_reg(REG_COLS, 9'(nc));
		write_reg(REG_ROWS, 9'(nr));
		write_reg(REG_MAX_VALUE, 9'(maxv));
		write_reg(REG_RED_OFS, ro);
		write_reg(REG_GREEN_OFS, go);
		write_reg(REG_BLUE_OFS, bo);
		write_reg(REG_GREY_THR, thr);
		cfg_we = 1'b0;
	endtask

	function automatic bit [6:0] pick_size();
		int k;
		k = $urandom_range(0, 19);
		if (k == 0)
			return 7'd0;
		if (k == 1)
			return 7'($urandom_range(65, 127));
		if (k < 4)
			return 7'd64;
		return 7'($urandom_range(1, 12));
	endfunction

	task automatic random_setup();
		bit [7:0] maxv;
		bit [8:0] thr;
		maxv = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
		if ($urandom_range(0, 4) == 0)
			maxv = 8'd255;
		thr = ($urandom_range(0, 2) == 0) ? 9'd256 : 9'($urandom_range(0, 511));
		configure(3'($urandom_range(0, 7)), pick_size(), pick_size(), maxv,
			9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
			9'($urandom_range(0, 511)), thr);
	endtask

	// reads are steered onto written entries through the mirror mapping
	task automatic random_item();
		bit       act;
		bit [5:0] r;
		bit [5:0] c;
		int       idx;
		int       tries;
		act = ($urandom_range(0, 99) < 40) ? ACT_STORE : ACT_READ;
		r   = pick_coord(sb.nrows());
		c   = pick_coord(sb.ncols());
		if (act == ACT_READ && !sb.read_allowed(r, c)) begin
			act = ACT_STORE;
			for (tries = 0; tries < 8 && act == ACT_STORE && sb.stored_cells.size() > 0; tries++) begin
				idx = sb.stored_cells[$urandom_range(0, sb.stored_cells.size() - 1)];
				if (!sb.outside(idx / MAX_DIM, idx % MAX_DIM)) begin
					idx = sb.source_index(idx / MAX_DIM, idx % MAX_DIM);
					r   = 6'(idx / MAX_DIM);
					c   = 6'(idx % MAX_DIM);
					act = ACT_READ;
				end
			end
		end
		send_request(act, r, c, pick_sample(), pick_sample(), pick_sample());
	endtask

	initial begin
		int  m;
		int  phase;
		int  n;
		bit  quiet;

		sb           = new();
		stall_cycles = 0;
		random_sent  = 0;
		clk          = 1'b0;
		arst_n       = 1'b0;
		start        = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		action       = ACT_STORE;
		row          = '0;
		col          = '0;
		red          = '0;
		green        = '0;
		blue         = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// corners and one interior pixel under the reset settings
		send_request(ACT_STORE, 6'd0, 6'd0, 8'd255, 8'd255, 8'd255);
		send_request(ACT_STORE, 6'd63, 6'd63, 8'd0, 8'd0, 8'd0);
		send_request(ACT_STORE, 6'd0, 6'd63, 8'd170, 8'd85, 8'd1);
		send_request(ACT_STORE, 6'd63, 6'd0, 8'd85, 8'd170, 8'd254);
		send_request(ACT_STORE, 6'd31, 6'd32, 8'd200, 8'd100, 8'd50);
		// every mode, unused codes included
		for (m = 0; m < 8; m++) begin
			configure(3'(m), 7'd64, 7'd64, 8'd255, 9'd0, 9'd0, 9'd0, 9'd256);
			send_request(ACT_READ, 6'd0, 6'd0, 8'd0, 8'd0, 8'd0);
			send_request(ACT_READ, 6'd63, 6'd63, 8'd0, 8'd0, 8'd0);
		end
		// zero width: everything outside
		configure(MODE_MIRROR_H, 7'd0, 7'd64, 8'd255, 9'd0, 9'd0, 9'd0, 9'd256);
		send_request(ACT_READ, 6'd0, 6'd0, 8'd0, 8'd0, 8'd0);
		send_request(ACT_STORE, 6'd5, 6'd5, 8'd9, 8'd9, 8'd9);
		// oversize width saturates, single row
		configure(MODE_MIRROR_H, 7'd127, 7'd1, 8'd255, 9'd0, 9'd0, 9'd0, 9'd256);
		send_request(ACT_READ, 6'd0, 6'd63, 8'd0, 8'd0, 8'd0);
		send_request(ACT_READ, 6'd1, 6'd0, 8'd0, 8'd0, 8'd0);

		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			case (phase)
				0: configure(MODE_ADJUST, 7'd64, 7'd64, 8'd0, 9'h0ff, 9'h100, 9'h101, 9'd256);
				1: configure(MODE_ADJUST, 7'd8, 7'd8, 8'd255, 9'h0ff, 9'h0ff, 9'h0ff, 9'd0);
				2: configure(MODE_ADJUST, 7'd8, 7'd8, 8'd100, 9'h1ff, 9'h180, 9'd37, 9'd511);
				3: configure(MODE_GREY, 7'd8, 7'd8, 8'd255, 9'd0, 9'd0, 9'd0, 9'd0);
				4: configure(MODE_GREY, 7'd8, 7'd8, 8'd255, 9'd0, 9'd0, 9'd0, 9'd511);
				5: configure(MODE_GREY, 7'd6, 7'd6, 8'd255, 9'd0, 9'd0, 9'd0, 9'd128);
				6: configure(MODE_MIRROR_BOTH, 7'd1, 7'd1, 8'd1, 9'd0, 9'd0, 9'd0, 9'd256);
				7: configure(MODE_MIRROR_BOTH, 7'd64, 7'd64, 8'd255, 9'd0, 9'd0, 9'd0, 9'd256);
				default: random_setup();
			endcase
			phase++;
			n     = $urandom_range(60, 140);
			quiet = ($urandom_range(0, 3) == 0);
			repeat (n) begin
				random_item();
				random_sent++;
				pause(gap_len(quiet));
			end
		end

		pause(0);
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- files.f -----
design/ift_pkg.sv
design/ift_ctrl.sv
design/ift_datapath.sv
design/image_frame_transform.sv
sim/image_frame_transform_tb.sv
